@@ rtl/lr_pkg.sv @@
`timescale 1ns / 1ps

package lr_pkg;

    localparam int COORD_BITS_DEF = 11;
    localparam int QUEUE_DEPTH    = 4;

    localparam int CFG_W          = 10;
    localparam int APB_DATA_W     = 32;
    localparam int APB_ADDR_W     = 3;

    localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 10'd800;
    localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 10'd600;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    typedef enum logic {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } reg_sel_t;

    typedef struct packed {
        logic line_active;
        logic out_free;
    } back_status_t;

endpackage

@@ rtl/line_rasterizer_core.sv @@
`timescale 1ns / 1ps
// Throughput: one item per cycle unless a step item waits for the output register;
// the stepper updates its error term and position per step, and the pixel is registered.
// A four-entry queue separates line setup from stepping, so either side may stall alone.
// Reset is synchronous and active low; it drops any active line and loads the screen
// size registers with 800 by 600.
module line_rasterizer_core #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF,
    parameter int QDEPTH     = lr_pkg::QUEUE_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // start_x, start_y, end_x, end_y, then zero padding.
    input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_tdata,
    // func.
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // pixel_x, pixel_y, then zero padding.
    output logic [((2*COORD_BITS+7)/8)*8-1:0] m_tdata,
    // on_screen.
    output logic                              m_tuser,
    output logic                              m_tlast,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lr_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lr_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lr_pkg::APB_DATA_W-1:0]     prdata,
    output logic                              pready
);

    localparam int IN_DATA_W  = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int ENTRY_W    = 5 * COORD_BITS + 5;

    logic [lr_pkg::CFG_W-1:0] width_reg, width_next;
    logic [lr_pkg::CFG_W-1:0] height_reg, height_next;
    logic                     cfg_write;
    lr_pkg::reg_sel_t         reg_sel;

    logic                     q_push, q_ready, q_valid, q_pop;
    logic [ENTRY_W-1:0]       q_wdata, q_rdata;
    lr_pkg::back_status_t     back_status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = lr_pkg::reg_sel_t'(paddr[2]);

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_write) begin
            unique case (reg_sel)
                lr_pkg::REG_SCREEN_WIDTH:  width_next  = pwdata[lr_pkg::CFG_W-1:0];
                lr_pkg::REG_SCREEN_HEIGHT: height_next = pwdata[lr_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            lr_pkg::REG_SCREEN_WIDTH:  prdata = lr_pkg::APB_DATA_W'(width_reg);
            lr_pkg::REG_SCREEN_HEIGHT: prdata = lr_pkg::APB_DATA_W'(height_reg);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= lr_pkg::SCREEN_WIDTH_RST;
            height_reg <= lr_pkg::SCREEN_HEIGHT_RST;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    lr_front #(
        .COORD_BITS (COORD_BITS),
        .IN_DATA_W  (IN_DATA_W),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_push   (q_push),
        .q_ready  (q_ready),
        .q_data   (q_wdata)
    );

    lr_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QDEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_ready (q_ready),
        .push_data  (q_wdata),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_rdata)
    );

    lr_back #(
        .COORD_BITS (COORD_BITS),
        .OUT_DATA_W (OUT_DATA_W),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_data        (q_rdata),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .status        (back_status)
    );

    a_width_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_write && reg_sel == lr_pkg::REG_SCREEN_WIDTH)
        |=> width_reg == $past(pwdata[lr_pkg::CFG_W-1:0]))
        else $error("screen width register missed a write");

    a_height_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_write && reg_sel == lr_pkg::REG_SCREEN_HEIGHT)
        |=> height_reg == $past(pwdata[lr_pkg::CFG_W-1:0]))
        else $error("screen height register missed a write");

    a_step_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && back_status.line_active && q_rdata[ENTRY_W-1] == lr_pkg::FUNC_STEP)
        |-> back_status.out_free)
        else $error("step item taken while the output register was full");

endmodule

@@ rtl/lr_front.sv @@
`timescale 1ns / 1ps

module lr_front #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF,
    parameter int IN_DATA_W  = ((4 * COORD_BITS + 7) / 8) * 8,
    parameter int ENTRY_W    = 5 * COORD_BITS + 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    output logic                 q_push,
    input  logic                 q_ready,
    output logic [ENTRY_W-1:0]   q_data
);

    localparam int C      = COORD_BITS;
    localparam int SPAN_W = C + 1;

    logic                 stage_valid_reg;
    logic                 stage_valid_next;
    logic                 stage_func_reg;
    logic [4*C-1:0]       stage_coords_reg;

    logic signed [C-1:0]      ax, ay, bx, by;
    logic signed [C:0]        diff_x, diff_y;
    logic [SPAN_W-1:0]        span_x, span_y;
    logic                     steep;
    logic signed [C-1:0]      a_maj, b_maj, a_min, b_min;
    logic                     order_swap;
    logic signed [C-1:0]      major_pos, major_end, minor_pos, minor_last;
    logic                     minor_down;
    logic [SPAN_W-1:0]        major_span, minor_span;

    assign s_tready = !stage_valid_reg || q_ready;
    assign q_push   = stage_valid_reg && q_ready;

    always_comb begin
        stage_valid_next = stage_valid_reg;
        if (s_tvalid && s_tready) begin
            stage_valid_next = 1'b1;
        end else if (q_push) begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            stage_func_reg   <= s_tuser;
            stage_coords_reg <= s_tdata[4*C-1:0];
        end
    end

    // Line setup: pick the major axis and order the endpoints along it.
    always_comb begin
        ax = $signed(stage_coords_reg[C-1:0]);
        ay = $signed(stage_coords_reg[2*C-1:C]);
        bx = $signed(stage_coords_reg[3*C-1:2*C]);
        by = $signed(stage_coords_reg[4*C-1:3*C]);

        diff_x = $signed({ax[C-1], ax}) - $signed({bx[C-1], bx});
        diff_y = $signed({ay[C-1], ay}) - $signed({by[C-1], by});
        span_x = diff_x[C] ? SPAN_W'(-diff_x) : SPAN_W'(diff_x);
        span_y = diff_y[C] ? SPAN_W'(-diff_y) : SPAN_W'(diff_y);
        steep  = span_y > span_x;

        a_maj = steep ? ay : ax;
        b_maj = steep ? by : bx;
        a_min = steep ? ax : ay;
        b_min = steep ? bx : by;

        order_swap = a_maj > b_maj;
        major_pos  = order_swap ? b_maj : a_maj;
        major_end  = order_swap ? a_maj : b_maj;
        minor_pos  = order_swap ? b_min : a_min;
        minor_last = order_swap ? a_min : b_min;
        minor_down = !(minor_pos < minor_last);

        major_span = steep ? span_y : span_x;
        minor_span = steep ? span_x : span_y;
    end

    assign q_data = {stage_func_reg, steep, minor_down, major_pos, major_end, minor_pos,
                     major_span, minor_span};

endmodule

@@ rtl/lr_queue.sv @@
`timescale 1ns / 1ps

module lr_queue #(
    parameter int WIDTH = 5 * lr_pkg::COORD_BITS_DEF + 5,
    parameter int DEPTH = lr_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/lr_back.sv @@
`timescale 1ns / 1ps

module lr_back #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF,
    parameter int OUT_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8,
    parameter int ENTRY_W    = 5 * COORD_BITS + 5
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    q_valid,
    output logic                    q_pop,
    input  logic [ENTRY_W-1:0]      q_data,
    input  logic [lr_pkg::CFG_W-1:0] screen_width,
    input  logic [lr_pkg::CFG_W-1:0] screen_height,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_DATA_W-1:0]   m_tdata,
    output logic                    m_tuser,
    output logic                    m_tlast,
    output lr_pkg::back_status_t    status
);

    localparam int C      = COORD_BITS;
    localparam int SPAN_W = C + 1;
    localparam int ERR_W  = C + 3;
    localparam int CMP_W  = ((C > lr_pkg::CFG_W) ? C : lr_pkg::CFG_W) + 1;

    logic                     e_func, e_steep, e_down;
    logic signed [C-1:0]      e_major_pos, e_major_end, e_minor_pos;
    logic [SPAN_W-1:0]        e_major_span, e_minor_span;

    logic                     active_reg, active_next;
    logic                     steep_reg, steep_next;
    logic                     down_reg, down_next;
    logic signed [C-1:0]      major_pos_reg, major_pos_next;
    logic signed [C-1:0]      major_end_reg, major_end_next;
    logic signed [C-1:0]      minor_pos_reg, minor_pos_next;
    logic [SPAN_W-1:0]        major_span_reg, major_span_next;
    logic [SPAN_W-1:0]        minor_span_reg, minor_span_next;
    logic signed [ERR_W-1:0]  err_reg, err_next;

    logic                     out_valid_reg, out_valid_next;
    logic signed [C-1:0]      out_x_reg, out_y_reg;
    logic                     out_on_reg, out_last_reg;

    logic                     out_free, is_start, emit;
    logic signed [C-1:0]      px, py;
    logic                     on_screen, last_pixel, minor_move;
    logic signed [ERR_W-1:0]  two_minor, two_major, major_cmp, err_sum;

    assign {e_func, e_steep, e_down, e_major_pos, e_major_end, e_minor_pos,
            e_major_span, e_minor_span} = q_data;

    assign out_free = !out_valid_reg || m_tready;
    assign is_start = e_func == lr_pkg::FUNC_START;
    assign q_pop    = q_valid && (is_start || !active_reg || out_free);
    assign emit     = q_pop && !is_start && active_reg;

    always_comb begin
        px         = steep_reg ? minor_pos_reg : major_pos_reg;
        py         = steep_reg ? major_pos_reg : minor_pos_reg;
        on_screen  = !px[C-1] && !py[C-1] &&
                     (CMP_W'($unsigned(px)) < CMP_W'(screen_width)) &&
                     (CMP_W'($unsigned(py)) < CMP_W'(screen_height));
        last_pixel = major_pos_reg >= major_end_reg;
        two_minor  = $signed({1'b0, minor_span_reg, 1'b0});
        two_major  = $signed({1'b0, major_span_reg, 1'b0});
        major_cmp  = $signed({2'b00, major_span_reg});
        err_sum    = err_reg + two_minor;
        minor_move = err_sum >= major_cmp;
    end

    always_comb begin
        active_next     = active_reg;
        steep_next      = steep_reg;
        down_next       = down_reg;
        major_pos_next  = major_pos_reg;
        major_end_next  = major_end_reg;
        minor_pos_next  = minor_pos_reg;
        major_span_next = major_span_reg;
        minor_span_next = minor_span_reg;
        err_next        = err_reg;
        if (q_pop && is_start) begin
            active_next     = 1'b1;
            steep_next      = e_steep;
            down_next       = e_down;
            major_pos_next  = e_major_pos;
            major_end_next  = e_major_end;
            minor_pos_next  = e_minor_pos;
            major_span_next = e_major_span;
            minor_span_next = e_minor_span;
            err_next        = '0;
        end else if (emit) begin
            if (last_pixel) begin
                active_next = 1'b0;
            end else begin
                major_pos_next = major_pos_reg + 1'b1;
                err_next       = minor_move ? err_sum - two_major : err_sum;
                if (minor_move) begin
                    minor_pos_next = down_reg ? minor_pos_reg - 1'b1 : minor_pos_reg + 1'b1;
                end
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg     <= 1'b0;
            steep_reg      <= 1'b0;
            down_reg       <= 1'b0;
            major_pos_reg  <= '0;
            major_end_reg  <= '0;
            minor_pos_reg  <= '0;
            major_span_reg <= '0;
            minor_span_reg <= '0;
            err_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            active_reg     <= active_next;
            steep_reg      <= steep_next;
            down_reg       <= down_next;
            major_pos_reg  <= major_pos_next;
            major_end_reg  <= major_end_next;
            minor_pos_reg  <= minor_pos_next;
            major_span_reg <= major_span_next;
            minor_span_reg <= minor_span_next;
            err_reg        <= err_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_x_reg    <= px;
            out_y_reg    <= py;
            out_on_reg   <= on_screen;
            out_last_reg <= last_pixel;
        end
    end

    assign m_tvalid           = out_valid_reg;
    assign m_tdata            = OUT_DATA_W'({out_y_reg, out_x_reg});
    assign m_tuser            = out_on_reg;
    assign m_tlast            = out_last_reg;
    assign status.line_active = active_reg;
    assign status.out_free    = out_free;

endmodule

@@ test/tb_line_rasterizer_core.sv @@
`timescale 1ns / 1ps

module tb_line_rasterizer_core;
    import lr_pkg::*;

    localparam int CB          = COORD_BITS_DEF;
    localparam int DIN_W       = ((4*CB+7)/8)*8;
    localparam int DOUT_W      = ((2*CB+7)/8)*8;
    localparam int CMIN        = -(1 << (CB-1));
    localparam int CMAX        = (1 << (CB-1)) - 1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic                 on;
        logic                 last;
    } pixel_t;

    typedef struct {
        logic func;
        int   sx;
        int   sy;
        int   ex;
        int   ey;
        bit   typed;
        int   px;
        int   py;
        bit   on;
        bit   last;
    } row_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DIN_W-1:0]      s_tdata  = '0;
    logic                  s_tuser  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [DOUT_W-1:0]     m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    line_rasterizer_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    logic [CFG_W-1:0]     cfg_width  = SCREEN_WIDTH_RST;
    logic [CFG_W-1:0]     cfg_height = SCREEN_HEIGHT_RST;
    bit                   line_on    = 1'b0;
    bit                   steep_line = 1'b0;
    bit                   minor_neg  = 1'b0;
    logic signed [CB-1:0] pos_major  = '0;
    logic signed [CB-1:0] end_major  = '0;
    logic signed [CB-1:0] pos_minor  = '0;
    logic [CB:0]          span_major = '0;
    logic [CB:0]          span_minor = '0;
    logic signed [CB+2:0] err_acc    = '0;

    pixel_t pending_pixels[$];
    bit     typed_en  = 1'b0;
    pixel_t typed_pix = '0;
    int     errors    = 0;
    int     cycle_count = 0;
    int     idle_pct  = 0;
    int     stall_pct = 0;
    bit     hold_request = 1'b0;
    int     hold_left = 0;

    row_t plan [24] = '{
        '{FUNC_STEP,  0, 0, 0, 0,             0, 0, 0, 0, 0},
        '{FUNC_START, 0, 0, 0, 0,             0, 0, 0, 0, 0},
        '{FUNC_STEP,  0, 0, 0, 0,             1, 0, 0, 1, 1},
        '{FUNC_STEP,  0, 0, 0, 0,             0, 0, 0, 0, 0},
        '{FUNC_START, 1023, 1023, 1023, 1023, 0, 0, 0, 0, 0},
        '{FUNC_STEP,  0, 0, 0, 0,             1, 1023, 1023, 0, 1},
        '{FUNC_START, -1024, -1024, -1024, -1024, 0, 0, 0, 0, 0},
        '{FUNC_STEP,  0, 0, 0, 0,             1, -1024, -1024, 0, 1},
        '{FUNC_START, 5, 7, 2, 7,             0, 0, 0, 0, 0},
        '{FUNC_STEP,  0, 0, 0, 0,             1, 2, 7, 1, 0},
        '{FUNC_STEP,  0, 0, 0, 0,             1, 3, 7, 1, 0},
        '{FUNC_STEP,  0, 0, 0, 0,             0, 0, 0, 0, 0},
        '{FUNC_STEP,  0, 0, 0, 0,             0, 0, 0, 0, 0},
        '{FUNC_START, -2, 3, 1, -3,           0, 0, 0, 0, 0},
        '{FUNC_STEP,  0, 0, 0, 0,             0, 0, 0, 0, 0},
        '{FUNC_STEP,  0, 0, 0, 0,             0, 0, 0, 0, 0},
        '{FUNC_STEP,  0, 0, 0, 0,             0, 0, 0, 0, 0},
        '{FUNC_START, 799, 599, 801, 601,     0, 0, 0, 0, 0},
        '{FUNC_STEP,  0, 0, 0, 0,             0, 0, 0, 0, 0},
        '{FUNC_STEP,  0, 0, 0, 0,             0, 0, 0, 0, 0},
        '{FUNC_STEP,  0, 0, 0, 0,             0, 0, 0, 0, 0},
        '{FUNC_START, -1024, 1023, 1023, -1024, 0, 0, 0, 0, 0},
        '{FUNC_STEP,  0, 0, 0, 0,             1, -1024, 1023, 0, 0},
        '{FUNC_STEP,  0, 0, 0, 0,             0, 0, 0, 0, 0}
    };

    function automatic int abs_diff(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic int clamp_coord(input int v);
        return (v < CMIN) ? CMIN : ((v > CMAX) ? CMAX : v);
    endfunction

    function automatic int pick_coord();
        if ($urandom_range(1) == 1) begin
            return int'($urandom_range(0, 1023));
        end
        return int'($urandom_range(0, 2047)) + CMIN;
    endfunction

    function automatic int pick_delta();
        if ($urandom_range(9) == 0) begin
            return int'($urandom_range(0, 400)) - 200;
        end
        return int'($urandom_range(0, 24)) - 12;
    endfunction

    // Returns 1 when the item yields a pixel, and updates the line state.
    function automatic bit rasterize_item(input logic f,
                                          input logic signed [CB-1:0] sx, sy, ex, ey,
                                          output pixel_t pix);
        int ax, ay, bx, by, t, mj, mn, e, w, h, px, py;
        pix = '0;
        if (f == FUNC_START) begin
            ax = sx;
            ay = sy;
            bx = ex;
            by = ey;
            steep_line = abs_diff(ay, by) > abs_diff(ax, bx);
            if (steep_line) begin
                t = ax; ax = ay; ay = t;
                t = bx; bx = by; by = t;
            end
            if (ax > bx) begin
                t = ax; ax = bx; bx = t;
                t = ay; ay = by; by = t;
            end
            pos_major  = CB'(ax);
            end_major  = CB'(bx);
            pos_minor  = CB'(ay);
            minor_neg  = !(ay < by);
            span_major = (CB+1)'(bx - ax);
            span_minor = (CB+1)'(abs_diff(ay, by));
            err_acc    = '0;
            line_on    = 1'b1;
            return 1'b0;
        end
        if (!line_on) begin
            return 1'b0;
        end
        mj = pos_major;
        mn = pos_minor;
        w  = cfg_width;
        h  = cfg_height;
        px = steep_line ? mn : mj;
        py = steep_line ? mj : mn;
        pix.x    = CB'(px);
        pix.y    = CB'(py);
        pix.on   = (px >= 0) && (py >= 0) && (px < w) && (py < h);
        pix.last = (mj >= int'(end_major));
        if (pix.last) begin
            line_on = 1'b0;
        end else begin
            e = int'(err_acc) + 2 * int'(span_minor);
            if (e >= int'(span_major)) begin
                mn = minor_neg ? mn - 1 : mn + 1;
                e  = e - 2 * int'(span_major);
            end
            pos_minor = CB'(mn);
            err_acc   = (CB+3)'(e);
            pos_major = CB'(mj + 1);
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 50) begin
            $display("cycle %0d: %s", cycle_count, msg);
        end
    endtask

    always @(posedge aclk) begin : watch
        pixel_t got;
        pixel_t want;
        pixel_t calc;
        bit     made;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.x    = m_tdata[CB-1:0];
                got.y    = m_tdata[2*CB-1:CB];
                got.on   = m_tuser;
                got.last = m_tlast;
                if (pending_pixels.size() == 0) begin
                    report_mismatch($sformatf("unexpected pixel (%0d, %0d)", got.x, got.y));
                end else begin
                    want = pending_pixels.pop_front();
                    if (got.x !== want.x)
                        report_mismatch($sformatf("pixel_x %0d, expected %0d", got.x, want.x));
                    if (got.y !== want.y)
                        report_mismatch($sformatf("pixel_y %0d, expected %0d", got.y, want.y));
                    if (got.on !== want.on)
                        report_mismatch($sformatf("on_screen %b, expected %b at (%0d, %0d)",
                                                  got.on, want.on, want.x, want.y));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("last_pixel %b, expected %b at (%0d, %0d)",
                                                  got.last, want.last, want.x, want.y));
                end
            end
            if (s_tvalid && s_tready) begin
                made = rasterize_item(s_tuser, s_tdata[CB-1:0], s_tdata[2*CB-1:CB],
                                      s_tdata[3*CB-1:2*CB], s_tdata[4*CB-1:3*CB], calc);
                if (made) begin
                    pending_pixels.push_back(typed_en ? typed_pix : calc);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_item(input logic f, input int sx, sy, ex, ey);
        logic [CB-1:0] vsx, vsy, vex, vey;
        vsx = CB'(sx);
        vsy = CB'(sy);
        vex = CB'(ex);
        vey = CB'(ey);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {{(DIN_W-4*CB){1'b0}}, vey, vex, vsy, vsx};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic write_screen(input reg_sel_t sel, input int val);
        logic [APB_DATA_W-1:0] word;
        word    = val & 32'h3FF;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= word;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (sel == REG_SCREEN_WIDTH) begin
            cfg_width = word[CFG_W-1:0];
        end else begin
            cfg_height = word[CFG_W-1:0];
        end
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== word) begin
            report_mismatch($sformatf("register %s reads %0d, expected %0d",
                                      sel.name(), prdata, word));
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic drain();
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic run_random(input int target);
        int made, kind, sx, sy, ex, ey, span, steps;
        made = 0;
        while (made < target) begin
            kind = $urandom_range(99);
            sx   = pick_coord();
            sy   = pick_coord();
            if (kind >= 94) begin
                ex = int'($urandom_range(0, 2047)) + CMIN;
                ey = int'($urandom_range(0, 2047)) + CMIN;
            end else begin
                ex = clamp_coord(sx + pick_delta());
                ey = clamp_coord(sy + pick_delta());
            end
            span = (abs_diff(sx, ex) > abs_diff(sy, ey)) ? abs_diff(sx, ex) : abs_diff(sy, ey);
            if (kind < 78) begin
                steps = span + 1;
            end else if (kind < 88) begin
                steps = $urandom_range(0, span);
            end else if (kind < 94) begin
                steps = span + 1 + $urandom_range(1, 3);
            end else begin
                steps = $urandom_range(0, 24);
            end
            send_item(FUNC_START, sx, sy, ex, ey);
            made++;
            for (int i = 0; i < steps; i++) begin
                send_item(FUNC_STEP, $urandom_range(0, 2047), $urandom_range(0, 2047),
                          $urandom_range(0, 2047), $urandom_range(0, 2047));
                if (i <= span) begin
                    made++;
                end
            end
        end
    endtask

    task automatic run_phase(input int w, h, idle, stall, target, input bit squeeze);
        write_screen(REG_SCREEN_WIDTH, w);
        write_screen(REG_SCREEN_HEIGHT, h);
        idle_pct  = idle;
        stall_pct = stall;
        if (squeeze) begin
            hold_request = 1'b1;
        end
        run_random(target);
        s_tvalid <= 1'b0;
        drain();
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        foreach (plan[i]) begin
            typed_en       = plan[i].typed;
            typed_pix.x    = CB'(plan[i].px);
            typed_pix.y    = CB'(plan[i].py);
            typed_pix.on   = plan[i].on;
            typed_pix.last = plan[i].last;
            send_item(plan[i].func, plan[i].sx, plan[i].sy, plan[i].ex, plan[i].ey);
        end
        typed_en = 1'b0;
        s_tvalid <= 1'b0;
        drain();
        run_phase(1023, 1023, 0, 0, 320, 1'b0);
        run_phase(0, 0, 75, 0, 300, 1'b0);
        run_phase(1, 1, 0, 75, 300, 1'b0);
        run_phase($urandom_range(1, 1023), $urandom_range(1, 1023), 35, 35, 300, 1'b0);
        run_phase(800, 600, 0, 0, 300, 1'b1);
        run_phase(1, 1023, 35, 35, 300, 1'b0);
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/lr_pkg.sv
rtl/lr_front.sv
rtl/lr_queue.sv
rtl/lr_back.sv
rtl/line_rasterizer_core.sv
test/tb_line_rasterizer_core.sv
